// ----- rtl/bmmd_pkg.sv -----
package bmmd_pkg;

  localparam int unsigned AddrW = 16;
  localparam int unsigned DataW = 8;
  localparam int unsigned IrqW = 5;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned QueueDepth = 4;

  localparam int unsigned WramAw = 15;
  localparam int unsigned VramAw = 14;
  localparam int unsigned OamAw = 8;
  localparam int unsigned SmallAw = 7;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_IRQ   = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    TGT_INTERNAL = 2'd0,
    TGT_ROM      = 2'd1,
    TGT_EXTRAM   = 2'd2
  } target_t;

  typedef enum logic [3:0] {
    REG_NONE,
    REG_CONST_FF,
    REG_CART,
    REG_VRAM,
    REG_WRAM,
    REG_OAM,
    REG_IO,
    REG_VBK,
    REG_SVBK,
    REG_IF,
    REG_HRAM,
    REG_IE,
    REG_IRQ
  } region_t;

  localparam logic [0:0] CFG_COLOR_MODE = 1'b0;
  localparam logic [0:0] CFG_CART_PRESENT = 1'b1;

  localparam logic [15:0] ADDR_VBK = 16'hFF4F;
  localparam logic [15:0] ADDR_SVBK = 16'hFF70;
  localparam logic [15:0] ADDR_IF = 16'hFF0F;
  localparam logic [6:0] IO_IF_OFF = 7'h0F;

  typedef struct packed {
    region_t             region;
    logic                wr;
    logic [AddrW-1:0]    addr;
    logic [DataW-1:0]    wdata;
    logic [IrqW-1:0]     irq;
    target_t             target;
  } cmd_t;

endpackage

// ----- rtl/bmmd_front.sv -----
module bmmd_front (
  input  logic [1:0]                  in_action,
  input  logic [bmmd_pkg::AddrW-1:0]  in_address,
  input  logic [bmmd_pkg::DataW-1:0]  in_write_data,
  input  logic [bmmd_pkg::IrqW-1:0]   in_irq_bits,
  input  logic                        cart_present,
  output bmmd_pkg::cmd_t              cmd
);

  logic [15:0] a;
  logic        is_rd;
  logic        is_wr;

  always_comb begin
    a = in_address;
    is_rd = (in_action == bmmd_pkg::ACT_READ);
    is_wr = (in_action == bmmd_pkg::ACT_WRITE);
    cmd.wr = is_wr;
    cmd.addr = in_address;
    cmd.wdata = in_write_data;
    cmd.irq = in_irq_bits;
    cmd.target = bmmd_pkg::TGT_INTERNAL;
    cmd.region = bmmd_pkg::REG_NONE;
    if (in_action == bmmd_pkg::ACT_IRQ) begin
      cmd.region = bmmd_pkg::REG_IRQ;
    end else if (is_rd || is_wr) begin
      priority if (a >= 16'h8000 && a <= 16'h9FFF) begin
        cmd.region = bmmd_pkg::REG_VRAM;
      end else if (a >= 16'hC000 && a <= 16'hFDFF) begin
        cmd.region = bmmd_pkg::REG_WRAM;
      end else if (a <= 16'h7FFF || (a >= 16'hA000 && a <= 16'hBFFF)) begin
        if (cart_present) begin
          cmd.region = bmmd_pkg::REG_CART;
          cmd.target = (a <= 16'h7FFF) ? bmmd_pkg::TGT_ROM : bmmd_pkg::TGT_EXTRAM;
        end else begin
          cmd.region = is_wr ? bmmd_pkg::REG_NONE : bmmd_pkg::REG_CONST_FF;
        end
      end else if (a <= 16'hFE9F) begin
        cmd.region = bmmd_pkg::REG_OAM;
      end else if (a <= 16'hFEFF) begin
        cmd.region = is_wr ? bmmd_pkg::REG_NONE : bmmd_pkg::REG_CONST_FF;
      end else if (a == bmmd_pkg::ADDR_VBK) begin
        cmd.region = bmmd_pkg::REG_VBK;
      end else if (a == bmmd_pkg::ADDR_SVBK) begin
        cmd.region = bmmd_pkg::REG_SVBK;
      end else if (a == bmmd_pkg::ADDR_IF) begin
        cmd.region = is_wr ? bmmd_pkg::REG_IO : bmmd_pkg::REG_IF;
      end else if (a <= 16'hFF7F) begin
        cmd.region = bmmd_pkg::REG_IO;
      end else if (a <= 16'hFFFE) begin
        cmd.region = bmmd_pkg::REG_HRAM;
      end else begin
        cmd.region = bmmd_pkg::REG_IE;
      end
    end
  end

endmodule

// ----- rtl/bmmd_queue.sv -----
module bmmd_queue #(
  parameter int unsigned DEPTH = bmmd_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bmmd_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output bmmd_pkg::cmd_t head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  bmmd_pkg::cmd_t      mem_r [DEPTH];
  logic [PW-1:0]       wp_r, rp_r;
  logic [PW:0]         cnt_r;

  assign full = (cnt_r == (PW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) begin
        wp_r <= (wp_r == PW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      end
      if (pop && !empty) begin
        rp_r <= (rp_r == PW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
    end
  end

endmodule

// ----- rtl/bmmd_back.sv -----
module bmmd_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       color_mode,
  input  logic                       cmd_valid,
  input  bmmd_pkg::cmd_t             cmd,
  output logic                       cmd_pop,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [bmmd_pkg::DataW-1:0] out_read_data,
  output logic [1:0]                 out_cart_target,
  output logic                       out_cart_write
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_HOLD
  } state_t;

  state_t        state_r;
  logic [bmmd_pkg::WramAw-1:0] clr_r;
  logic [7:0]    wram_mem [32768];
  logic [7:0]    vram_mem [16384];
  logic [7:0]    oam_mem [160];
  logic [7:0]    hram_mem [128];
  logic [7:0]    io_mem [128];
  logic [7:0]    ie_r;
  logic          vbank_r;
  logic [2:0]    wbank_r;
  logic [7:0]    wram_q_r, vram_q_r, oam_q_r, hram_q_r, io_q_r;
  bmmd_pkg::region_t region_r;
  bmmd_pkg::region_t region_nxt;
  logic [7:0]    imm_r;
  logic [7:0]    imm_nxt;
  logic [7:0]    if_r;
  logic [7:0]    rdata_r;
  logic [1:0]    tgt_r;
  logic          cw_r;

  logic          take;
  logic          rd;
  logic          clearing;
  logic [bmmd_pkg::WramAw-1:0]  wram_a;
  logic [bmmd_pkg::VramAw-1:0]  vram_a;
  logic [bmmd_pkg::OamAw-1:0]   oam_a;
  logic [bmmd_pkg::SmallAw-1:0] small_a;
  logic [12:0]   woff;
  logic [2:0]    wsel;
  logic [7:0]    sel_q;

  assign clearing = (state_r == ST_CLEAR);
  assign take = cmd_valid && (state_r == ST_IDLE);
  assign cmd_pop = take;
  assign rd = !cmd.wr;
  assign out_empty = (state_r != ST_HOLD);
  assign out_read_data = rdata_r;
  assign out_cart_target = tgt_r;
  assign out_cart_write = cw_r;

  always_comb begin
    woff = cmd.addr[12:0];
    wsel = woff[12] ? wbank_r : 3'd0;
    wram_a = clearing ? clr_r : {wsel, woff[11:0]};
    vram_a = clearing ? clr_r[13:0] : {vbank_r, cmd.addr[12:0]};
    oam_a = clearing ? clr_r[7:0] : cmd.addr[7:0];
    small_a = clearing ? clr_r[6:0] : cmd.addr[6:0];
  end

  always_ff @(posedge clk) begin
    if (clearing || (take && cmd.wr && cmd.region == bmmd_pkg::REG_WRAM)) begin
      wram_mem[wram_a] <= clearing ? 8'h00 : cmd.wdata;
    end
    wram_q_r <= wram_mem[wram_a];
  end

  always_ff @(posedge clk) begin
    if ((clearing && !clr_r[14])
        || (take && cmd.wr && cmd.region == bmmd_pkg::REG_VRAM)) begin
      vram_mem[vram_a] <= clearing ? 8'h00 : cmd.wdata;
    end
    vram_q_r <= vram_mem[vram_a];
  end

  always_ff @(posedge clk) begin
    if ((clearing && clr_r < 15'd160)
        || (take && cmd.wr && cmd.region == bmmd_pkg::REG_OAM)) begin
      oam_mem[oam_a] <= clearing ? 8'h00 : cmd.wdata;
    end
    oam_q_r <= oam_mem[oam_a];
  end

  always_ff @(posedge clk) begin
    if ((clearing && clr_r < 15'd128)
        || (take && cmd.wr && cmd.region == bmmd_pkg::REG_HRAM)) begin
      hram_mem[small_a] <= clearing ? 8'h00 : cmd.wdata;
    end
    hram_q_r <= hram_mem[small_a];
  end

  always_ff @(posedge clk) begin
    if ((clearing && clr_r < 15'd128)
        || (take && cmd.wr && cmd.region == bmmd_pkg::REG_IO)) begin
      io_mem[small_a] <= clearing ? 8'h00 : cmd.wdata;
    end
    io_q_r <= io_mem[small_a];
  end

  // IF kept in flops too since interrupt requests read-modify-write it
  always_comb begin
    unique case (region_r)
      bmmd_pkg::REG_WRAM: sel_q = wram_q_r;
      bmmd_pkg::REG_VRAM: sel_q = vram_q_r;
      bmmd_pkg::REG_OAM:  sel_q = oam_q_r;
      bmmd_pkg::REG_HRAM: sel_q = hram_q_r;
      bmmd_pkg::REG_IO:   sel_q = io_q_r;
      default:            sel_q = imm_r;
    endcase
  end

  always_comb begin
    region_nxt = cmd.region;
    if (cmd.wr || cmd.region == bmmd_pkg::REG_CART) region_nxt = bmmd_pkg::REG_NONE;
    imm_nxt = '0;
    unique case (cmd.region)
      bmmd_pkg::REG_CONST_FF: imm_nxt = 8'hFF;
      bmmd_pkg::REG_VBK: begin
        if (rd) imm_nxt = color_mode ? {7'h7F, vbank_r} : 8'hFF;
      end
      bmmd_pkg::REG_SVBK: begin
        if (rd) imm_nxt = color_mode ? {5'h1F, wbank_r} : 8'hFF;
      end
      bmmd_pkg::REG_IF: imm_nxt = if_r | 8'hE0;
      bmmd_pkg::REG_IE: begin
        if (rd) imm_nxt = ie_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      ie_r <= '0;
      vbank_r <= 1'b0;
      wbank_r <= 3'd1;
      if_r <= '0;
      rdata_r <= '0;
      tgt_r <= '0;
      cw_r <= 1'b0;
      region_r <= bmmd_pkg::REG_NONE;
      imm_r <= '0;
    end else begin
      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == 15'h7FFF) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (take) begin
            region_r <= region_nxt;
            imm_r <= imm_nxt;
            tgt_r <= cmd.target;
            cw_r <= (cmd.region == bmmd_pkg::REG_CART) && cmd.wr;
            state_r <= ST_READ;
            unique case (cmd.region)
              bmmd_pkg::REG_VBK: begin
                if (cmd.wr && color_mode) vbank_r <= cmd.wdata[0];
              end
              bmmd_pkg::REG_SVBK: begin
                if (cmd.wr && color_mode) begin
                  wbank_r <= (cmd.wdata[2:0] == 3'd0) ? 3'd1 : cmd.wdata[2:0];
                end
              end
              bmmd_pkg::REG_IE: begin
                if (cmd.wr) ie_r <= cmd.wdata;
              end
              bmmd_pkg::REG_IRQ: if_r <= if_r | {3'b000, cmd.irq};
              bmmd_pkg::REG_IO: begin
                if (cmd.wr && cmd.addr[6:0] == bmmd_pkg::IO_IF_OFF) if_r <= cmd.wdata;
              end
              default: ;
            endcase
          end
        end
        ST_READ: begin
          rdata_r <= sel_q;
          state_r <= ST_HOLD;
        end
        ST_HOLD: begin
          if (out_pop) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/banked_memory_map_decoder.sv -----
// channel | direction | handshake
// in_*    | input     | push / full, taken when push && !full
// out_*   | output    | empty / pop, taken when pop && !empty
// cfg_*   | input     | cfg_we, taken every edge it is high
// In the back end each transaction goes through memory read, register and hand off,
// an order set by the registered read port of the banked RAMs; a 4-entry queue decouples input.
// After reset a clearing pass over all 32768 WRAM addresses zeroes the RAMs; input queues meanwhile.
// Reset is synchronous, active low. A stalled result holds the back end.
module banked_memory_map_decoder #(
  parameter int unsigned QUEUE_DEPTH = bmmd_pkg::QueueDepth
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 push,
  output logic                                 full,
  input  logic [1:0]                           in_action,
  input  logic [bmmd_pkg::AddrW-1:0]           in_address,
  input  logic [bmmd_pkg::DataW-1:0]           in_write_data,
  input  logic [bmmd_pkg::IrqW-1:0]            in_irq_bits,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [bmmd_pkg::DataW-1:0]           out_read_data,
  output logic [1:0]                           out_cart_target,
  output logic                                 out_cart_write,
  input  logic                                 cfg_we,
  input  logic [bmmd_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [0:0]                           cfg_data
);

  logic           color_mode_r;
  logic           cart_present_r;
  bmmd_pkg::cmd_t f_cmd, q_head;
  logic           q_empty;
  logic           q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r <= 1'b0;
      cart_present_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bmmd_pkg::CFG_COLOR_MODE:   color_mode_r <= cfg_data[0];
        bmmd_pkg::CFG_CART_PRESENT: cart_present_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  bmmd_front u_front (
    .in_action     (in_action),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .in_irq_bits   (in_irq_bits),
    .cart_present  (cart_present_r),
    .cmd           (f_cmd)
  );

  bmmd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (f_cmd),
    .full     (full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  bmmd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .color_mode      (color_mode_r),
    .cmd_valid       (!q_empty),
    .cmd             (q_head),
    .cmd_pop         (q_pop),
    .out_empty       (empty),
    .out_pop         (pop),
    .out_read_data   (out_read_data),
    .out_cart_target (out_cart_target),
    .out_cart_write  (out_cart_write)
  );

`ifndef SYNTHESIS
  a_fwd_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_cart_target != bmmd_pkg::TGT_INTERNAL) |-> (out_read_data == 8'h00))
    else $error("forwarded transaction carries read data");
  a_cw_needs_target: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_cart_write) |-> (out_cart_target != bmmd_pkg::TGT_INTERNAL))
    else $error("cart write without target");
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !q_pop)
    else $error("back end took two transactions back to back");
`endif

endmodule
